/* hw/rtl/dars_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// Shared types, constants and helpers of the disk-arm request scheduler.
// No dependencies; every other file of the block takes its names from here.
package dars_pkg;

	localparam int unsigned MAX_REQUESTS = 32;
	localparam int unsigned CNT_W        = $clog2(MAX_REQUESTS + 1);
	localparam int unsigned TRACK_W      = 16;
	localparam int unsigned TOT_W        = 22;
	localparam int unsigned MODE_W       = 2;
	localparam int unsigned CFG_IDX_W    = 1;
	localparam int unsigned CFG_DATA_W   = 16;

	// command codes
	localparam logic CMD_ADD   = 1'b0;
	localparam logic CMD_START = 1'b1;

	// schedule modes
	localparam logic [MODE_W-1:0] MODE_FCFS  = 2'd0;
	localparam logic [MODE_W-1:0] MODE_SCAN  = 2'd1;
	localparam logic [MODE_W-1:0] MODE_CSCAN = 2'd2;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_SCHED_MODE  = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TRACK_LIMIT = 1'd1;

	typedef enum logic [2:0] {
		OP_HOLD,
		OP_INSERT,
		OP_UP_STEP,
		OP_ARR_POP,
		OP_SRT_POP
	} cell_op_t;

	// broadcast control for the whole row
	typedef struct packed {
		cell_op_t             op;
		logic [TRACK_W-1:0]   value;
		logic                 rotate;
		logic [TRACK_W-1:0]   wrap_val;
	} cell_ctl_t;

	// per-cell position flags
	typedef struct packed {
		logic valid;
		logic arr_slot;
		logic tail;
	} cell_pos_t;

	function automatic logic [TRACK_W-1:0] absdiff(input logic [TRACK_W-1:0] a,
		input logic [TRACK_W-1:0] b);
		absdiff = (a > b) ? (a - b) : (b - a);
	endfunction

endpackage
`default_nettype wire

/* hw/rtl/dars_req_if.sv */
`timescale 1ns / 1ps
`default_nettype none
// Request channel: one word carries a command and a track.
// Depends on dars_pkg for field widths.
interface dars_req_if;
	logic                          valid;
	logic                          ready;
	logic                          command;
	logic [dars_pkg::TRACK_W-1:0]  track;

	modport source(output valid, output command, output track, input ready);
	modport sink(input valid, input command, input track, output ready);
endinterface
`default_nettype wire

/* hw/rtl/dars_res_if.sv */
`timescale 1ns / 1ps
`default_nettype none
// Result channel: one word per visited arm position.
// Depends on dars_pkg for field widths.
interface dars_res_if;
	logic                          valid;
	logic                          ready;
	logic [dars_pkg::TRACK_W-1:0]  visit_track;
	logic [dars_pkg::TOT_W-1:0]    total_movement;
	logic                          last;

	modport source(output valid, output visit_track, output total_movement, output last,
		input ready);
	modport sink(input valid, input visit_track, input total_movement, input last,
		output ready);
endinterface
`default_nettype wire

/* hw/rtl/dars_cfg_if.sv */
`timescale 1ns / 1ps
`default_nettype none
// Configuration write channel: register index and write data.
// Depends on dars_pkg for field widths.
interface dars_cfg_if;
	logic                             valid;
	logic                             ready;
	logic [dars_pkg::CFG_IDX_W-1:0]   index;
	logic [dars_pkg::CFG_DATA_W-1:0]  data;

	modport source(output valid, output index, output data, input ready);
	modport sink(input valid, input index, input data, output ready);
endinterface
`default_nettype wire

/* hw/rtl/dars_cell.sv */
`timescale 1ns / 1ps
`default_nettype none
// One cell of the request row: a sorted-chain slot and an arrival-chain slot.
// Depends on dars_pkg for the control and position types.
module dars_cell (
	input  wire logic                          clk,
	input  wire dars_pkg::cell_ctl_t           ctl,
	input  wire dars_pkg::cell_pos_t           pos,
	input  wire logic [dars_pkg::TRACK_W-1:0]  left_srt,
	input  wire logic [dars_pkg::TRACK_W-1:0]  left_arr,
	input  wire logic                          left_gt,
	input  wire logic [dars_pkg::TRACK_W-1:0]  right_srt,
	input  wire logic [dars_pkg::TRACK_W-1:0]  right_arr,
	output logic [dars_pkg::TRACK_W-1:0]       srt,
	output logic [dars_pkg::TRACK_W-1:0]       arr,
	output logic                               gt
);

	logic [dars_pkg::TRACK_W-1:0] srt_q;
	logic [dars_pkg::TRACK_W-1:0] arr_q;

	// empty slots count as greater so the insert point is found below them
	assign gt  = !pos.valid || (srt_q > ctl.value);
	assign srt = srt_q;
	assign arr = arr_q;

	always_ff @(posedge clk) begin
		case (ctl.op)
			dars_pkg::OP_INSERT: begin
				if (left_gt) begin
					srt_q <= left_srt;
				end else if (gt) begin
					srt_q <= ctl.value;
				end
				if (pos.arr_slot) begin
					arr_q <= ctl.value;
				end
			end
			dars_pkg::OP_UP_STEP: begin
				// shift down; the tail slot takes the head word when it rotates
				srt_q <= (pos.tail && ctl.rotate) ? ctl.wrap_val : right_srt;
				if (ctl.rotate) begin
					arr_q <= left_arr;
				end
			end
			dars_pkg::OP_ARR_POP: begin
				arr_q <= right_arr;
			end
			dars_pkg::OP_SRT_POP: begin
				srt_q <= right_srt;
			end
			default: begin
			end
		endcase
	end

endmodule
`default_nettype wire

/* hw/rtl/disk_arm_request_scheduler.sv */
`timescale 1ns / 1ps
`default_nettype none
// Disk-arm request scheduler: a row of MAX_REQUESTS cells that keeps the queued tracks
// both in arrival order and in ascending order, plus a sequencer that walks the row.
// Depends on dars_pkg, dars_req_if, dars_res_if, dars_cfg_if and dars_cell.
//
// An add word (command 0) queues its track, clamped to track_limit, and gives no
// result; adds beyond MAX_REQUESTS are dropped. A start word (command 1) gives
// the head position and starts a run: the head word comes out first, then the visiting
// order for the mode in sched_mode (0 or 3 first-come-first-served, 1 SCAN, 2 C-SCAN).
// total_movement is nonzero only on the word with last set; after it the queue is
// empty. The block handles one run at a time and takes no input word during a run.
// Each result word passes through the shared output register, and the row shifts one
// cell per cycle unless a result word that it must give is held by the consumer. The
// upward pass of SCAN and C-SCAN steps through every entry once, then closes the leg,
// and the return leg pops the entries below the head again. Slow result consumers
// stretch a run by their stall cycles. Configuration writes are always taken and must
// only be issued while the block is idle.
module disk_arm_request_scheduler (
	input  wire logic  clk,
	input  wire logic  arst_n,
	dars_req_if.sink   req,
	dars_res_if.source res,
	dars_cfg_if.sink   cfg
);

	localparam int unsigned CW = dars_pkg::CNT_W;
	localparam int unsigned TW = dars_pkg::TRACK_W;
	localparam int unsigned NR = dars_pkg::MAX_REQUESTS;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_HEAD,
		ST_FCFS,
		ST_UP,
		ST_LIMIT,
		ST_WRAP0,
		ST_DOWN,
		ST_WRAPUP
	} state_t;

	state_t                        state_q;
	logic [dars_pkg::MODE_W-1:0]   mode_q;
	logic [TW-1:0]                 limit_q;
	logic [CW-1:0]                 cnt_q;    // queued requests
	logic [CW-1:0]                 k_q;      // steps left in the current leg
	logic [CW-1:0]                 m_q;      // live entries in the sorted chain
	logic [CW-1:0]                 b_q;      // entries found below the head
	logic [TW-1:0]                 head_q;
	logic [TW-1:0]                 pos_q;
	logic [dars_pkg::TOT_W-1:0]    total_q;

	logic                          res_valid_q;
	logic [TW-1:0]                 res_track_q;
	logic [dars_pkg::TOT_W-1:0]    res_total_q;
	logic                          res_last_q;

	logic [TW-1:0]                 srt_w [NR];
	logic [TW-1:0]                 arr_w [NR];
	logic                          gt_w  [NR];

	dars_pkg::cell_ctl_t           ctl;
	logic                          in_ready;
	logic                          req_take;
	logic                          out_free;
	logic                          is_fcfs;
	logic                          up_rot;
	logic                          step;
	logic                          emit;
	logic [TW-1:0]                 emit_track;
	logic                          emit_last;
	logic [dars_pkg::TOT_W-1:0]    tot_n;
	logic [TW-1:0]                 clamped;

	assign in_ready  = (state_q == ST_IDLE);
	assign req.ready = in_ready;
	assign req_take  = req.valid && in_ready;
	assign out_free  = !res_valid_q || res.ready;
	assign is_fcfs   = !(mode_q == dars_pkg::MODE_SCAN || mode_q == dars_pkg::MODE_CSCAN);
	assign clamped   = (req.track > limit_q) ? limit_q : req.track;
	assign up_rot    = srt_w[0] < head_q;

	assign res.valid          = res_valid_q;
	assign res.visit_track    = res_track_q;
	assign res.total_movement = res_total_q;
	assign res.last           = res_last_q;

	assign cfg.ready = 1'b1;

	// Configuration registers: take every write.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= dars_pkg::MODE_FCFS;
			limit_q <= '1;
		end else if (cfg.valid) begin
			case (cfg.index)
				dars_pkg::REG_SCHED_MODE:  mode_q  <= cfg.data[dars_pkg::MODE_W-1:0];
				dars_pkg::REG_TRACK_LIMIT: limit_q <= cfg.data[TW-1:0];
				default: begin
				end
			endcase
		end
	end

	// Sequencer decode: what the row does and what goes to the output this cycle.
	always_comb begin
		ctl.op       = dars_pkg::OP_HOLD;
		ctl.value    = clamped;
		ctl.rotate   = 1'b0;
		ctl.wrap_val = srt_w[0];
		step         = 1'b0;
		emit         = 1'b0;
		emit_track   = '0;
		emit_last    = 1'b0;
		tot_n        = total_q;
		case (state_q)
			ST_IDLE: begin
				// insert an add word unless the row is full
				if (req_take && req.command == dars_pkg::CMD_ADD && cnt_q < CW'(NR)) begin
					ctl.op = dars_pkg::OP_INSERT;
				end
			end
			ST_HEAD: begin
				if (out_free) begin
					emit       = 1'b1;
					emit_track = head_q;
					emit_last  = is_fcfs && (cnt_q == '0);
					step       = 1'b1;
				end
			end
			ST_FCFS: begin
				tot_n = total_q + dars_pkg::TOT_W'(dars_pkg::absdiff(pos_q, arr_w[0]));
				if (out_free) begin
					emit       = 1'b1;
					emit_track = arr_w[0];
					emit_last  = (k_q == CW'(1));
					ctl.op     = dars_pkg::OP_ARR_POP;
					step       = 1'b1;
				end
			end
			ST_UP: begin
				// below the head: rotate to the tail and push on the return stack
				if (k_q == '0) begin
					step = 1'b1;
				end else if (up_rot) begin
					ctl.op     = dars_pkg::OP_UP_STEP;
					ctl.rotate = 1'b1;
					step       = 1'b1;
				end else if (out_free) begin
					emit       = 1'b1;
					emit_track = srt_w[0];
					ctl.op     = dars_pkg::OP_UP_STEP;
					step       = 1'b1;
				end
			end
			ST_LIMIT: begin
				tot_n = total_q + dars_pkg::TOT_W'(dars_pkg::absdiff(head_q, limit_q));
				if (out_free) begin
					emit       = 1'b1;
					emit_track = limit_q;
					emit_last  = (b_q == '0);
					step       = 1'b1;
				end
			end
			ST_WRAP0: begin
				tot_n = total_q + dars_pkg::TOT_W'(limit_q);
				if (out_free) begin
					emit = 1'b1;
					step = 1'b1;
				end
			end
			ST_DOWN: begin
				// the stack pops largest first; the last pop is the lowest request,
				// and only the sweep from the limit down to it adds movement
				if (k_q == CW'(1)) begin
					tot_n = total_q + dars_pkg::TOT_W'(dars_pkg::absdiff(limit_q, arr_w[0]));
				end
				if (out_free) begin
					emit       = 1'b1;
					emit_track = arr_w[0];
					emit_last  = (k_q == CW'(1));
					ctl.op     = dars_pkg::OP_ARR_POP;
					step       = 1'b1;
				end
			end
			ST_WRAPUP: begin
				// the climb from track 0 ends at the highest request below the head
				if (k_q == CW'(1)) begin
					tot_n = total_q + dars_pkg::TOT_W'(srt_w[0]);
				end
				if (out_free) begin
					emit       = 1'b1;
					emit_track = srt_w[0];
					emit_last  = (k_q == CW'(1));
					ctl.op     = dars_pkg::OP_SRT_POP;
					step       = 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	// Sequencer state and the output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			k_q         <= '0;
			m_q         <= '0;
			b_q         <= '0;
			head_q      <= '0;
			pos_q       <= '0;
			total_q     <= '0;
			res_valid_q <= 1'b0;
			res_track_q <= '0;
			res_total_q <= '0;
			res_last_q  <= 1'b0;
		end else begin
			if (emit) begin
				res_valid_q <= 1'b1;
				res_track_q <= emit_track;
				res_total_q <= emit_last ? tot_n : '0;
				res_last_q  <= emit_last;
			end else if (res.ready) begin
				res_valid_q <= 1'b0;
			end

			if (step) begin
				total_q <= tot_n;
			end

			case (state_q)
				ST_IDLE: begin
					if (req_take) begin
						if (req.command == dars_pkg::CMD_START) begin
							head_q  <= req.track;
							total_q <= '0;
							state_q <= ST_HEAD;
						end else if (cnt_q < CW'(NR)) begin
							cnt_q <= cnt_q + CW'(1);
						end
					end
				end
				ST_HEAD: begin
					if (step) begin
						pos_q <= head_q;
						k_q   <= cnt_q;
						m_q   <= cnt_q;
						b_q   <= '0;
						if (!is_fcfs) begin
							state_q <= ST_UP;
						end else if (cnt_q == '0) begin
							state_q <= ST_IDLE;
						end else begin
							state_q <= ST_FCFS;
						end
					end
				end
				ST_FCFS: begin
					if (step) begin
						pos_q <= arr_w[0];
						k_q   <= k_q - CW'(1);
						if (k_q == CW'(1)) begin
							cnt_q   <= '0;
							state_q <= ST_IDLE;
						end
					end
				end
				ST_UP: begin
					if (step) begin
						if (k_q == '0) begin
							state_q <= ST_LIMIT;
						end else begin
							k_q <= k_q - CW'(1);
							if (up_rot) begin
								b_q <= b_q + CW'(1);
							end else begin
								m_q <= m_q - CW'(1);
							end
						end
					end
				end
				ST_LIMIT: begin
					if (step) begin
						k_q <= b_q;
						if (b_q == '0) begin
							cnt_q   <= '0;
							state_q <= ST_IDLE;
						end else if (mode_q == dars_pkg::MODE_SCAN) begin
							state_q <= ST_DOWN;
						end else begin
							state_q <= ST_WRAP0;
						end
					end
				end
				ST_WRAP0: begin
					if (step) begin
						state_q <= ST_WRAPUP;
					end
				end
				ST_DOWN, ST_WRAPUP: begin
					if (step) begin
						k_q <= k_q - CW'(1);
						if (k_q == CW'(1)) begin
							cnt_q   <= '0;
							state_q <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// The row of cells; neighbors hand words to each other when the row shifts.
	for (genvar i = 0; i < NR; i++) begin : g_cell
		localparam logic [CW-1:0] IDX      = CW'(i);
		localparam logic [CW-1:0] IDX_NEXT = CW'(i + 1);

		dars_pkg::cell_pos_t       cpos;
		logic [TW-1:0]             l_srt;
		logic [TW-1:0]             l_arr;
		logic                      l_gt;
		logic [TW-1:0]             r_srt;
		logic [TW-1:0]             r_arr;

		assign cpos.valid    = IDX < cnt_q;
		assign cpos.arr_slot = IDX == cnt_q;
		assign cpos.tail     = IDX_NEXT == m_q;

		if (i == 0) begin : g_first
			// the front cell pushes the head of the sorted chain onto the stack
			assign l_srt = '0;
			assign l_arr = srt_w[0];
			assign l_gt  = 1'b0;
		end else begin : g_inner
			assign l_srt = srt_w[i-1];
			assign l_arr = arr_w[i-1];
			assign l_gt  = gt_w[i-1];
		end

		if (i == NR - 1) begin : g_last
			assign r_srt = '0;
			assign r_arr = '0;
		end else begin : g_mid
			assign r_srt = srt_w[i+1];
			assign r_arr = arr_w[i+1];
		end

		dars_cell u_cell (
			.clk       (clk),
			.ctl       (ctl),
			.pos       (cpos),
			.left_srt  (l_srt),
			.left_arr  (l_arr),
			.left_gt   (l_gt),
			.right_srt (r_srt),
			.right_arr (r_arr),
			.srt       (srt_w[i]),
			.arr       (arr_w[i]),
			.gt        (gt_w[i])
		);
	end

`ifndef SYNTHESIS
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(NR))
		else $error("request count beyond row depth");

	a_up_balance: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_UP |-> m_q == k_q + b_q)
		else $error("sorted chain occupancy out of step with upward pass");

	a_start_runs: assert property (@(posedge clk) disable iff (!arst_n)
		req.valid && req.ready && req.command == dars_pkg::CMD_START |=> state_q == ST_HEAD)
		else $error("start word did not begin a run");

	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		emit && emit_last |=> state_q == ST_IDLE && cnt_q == '0)
		else $error("run ended without emptying the queue");
`endif

endmodule
`default_nettype wire

/* sim/dars_visit_checker.sv */
`timescale 1ns / 1ps
// Passive checker of the disk-arm request scheduler: watches the three channels,
// predicts the visiting order of every run and compares the result words.
// Depends on dars_pkg and the request, result and configuration interfaces.
module dars_visit_checker (
	input  logic        clk,
	input  logic        arst_n,
	dars_req_if         req,
	dars_res_if         res,
	dars_cfg_if         cfg,
	output int unsigned fail_count,
	output int unsigned outstanding,
	output int unsigned results_checked,
	output int unsigned runs_checked
);
	import dars_pkg::*;

	typedef struct packed {
		logic [TRACK_W-1:0] visit_track;
		logic [TOT_W-1:0]   total_movement;
		logic               last;
	} visit_t;

	logic [TRACK_W-1:0] queued_tracks [MAX_REQUESTS];
	int unsigned        queued_count;
	logic [MODE_W-1:0]  mode_now;
	logic [TRACK_W-1:0] limit_now;
	visit_t             expected_visits [$];

	function automatic int unsigned span(input logic [TRACK_W-1:0] a,
		input logic [TRACK_W-1:0] b);
		span = (a > b) ? int'(a) - int'(b) : int'(b) - int'(a);
	endfunction

	// Build the route of one run from the queued tracks and append its words.
	task automatic plan_visits(input logic [TRACK_W-1:0] head);
		logic [TRACK_W-1:0] route [$];
		logic [TRACK_W-1:0] ascending [$];
		logic [TRACK_W-1:0] pos;
		int unsigned        total;
		int unsigned        split;
		visit_t             v;
		total = 0;
		route.push_back(head);
		if (mode_now == MODE_SCAN || mode_now == MODE_CSCAN) begin
			for (int i = 0; i < queued_count; i++)
				ascending.push_back(queued_tracks[i]);
			ascending.sort();
			// first entry at or above the head; none means the upward leg is empty
			split = queued_count;
			for (int i = queued_count - 1; i >= 0; i--)
				if (ascending[i] >= head)
					split = i;
			for (int i = split; i < queued_count; i++)
				route.push_back(ascending[i]);
			route.push_back(limit_now);
			total += span(head, limit_now);
			if (split > 0) begin
				if (mode_now == MODE_SCAN) begin
					total += span(limit_now, ascending[0]);
					for (int i = split; i > 0; i--)
						route.push_back(ascending[i-1]);
				end else begin
					total += limit_now;
					route.push_back('0);
					total += ascending[split-1];
					for (int i = 0; i < split; i++)
						route.push_back(ascending[i]);
				end
			end
		end else begin
			pos = head;
			for (int i = 0; i < queued_count; i++) begin
				total += span(pos, queued_tracks[i]);
				pos = queued_tracks[i];
				route.push_back(pos);
			end
		end
		for (int i = 0; i < route.size(); i++) begin
			v.visit_track    = route[i];
			v.last           = (i == route.size() - 1);
			v.total_movement = v.last ? TOT_W'(total) : '0;
			expected_visits.push_back(v);
		end
		queued_count = 0;
	endtask

	always @(posedge clk) begin
		visit_t want;
		if (!arst_n) begin
			queued_count    = 0;
			mode_now        = MODE_FCFS;
			limit_now       = '1;
			fail_count      = 0;
			results_checked = 0;
			runs_checked    = 0;
			expected_visits.delete();
		end else begin
			if (res.valid && res.ready) begin
				if (expected_visits.size() == 0) begin
					$error("unexpected result word: visit_track %0d, total_movement %0d, last %0d",
						res.visit_track, res.total_movement, res.last);
					fail_count++;
				end else begin
					want = expected_visits.pop_front();
					if (res.visit_track !== want.visit_track) begin
						$error("visit_track: expected %0d, actual %0d",
							want.visit_track, res.visit_track);
						fail_count++;
					end
					if (res.total_movement !== want.total_movement) begin
						$error("total_movement: expected %0d, actual %0d",
							want.total_movement, res.total_movement);
						fail_count++;
					end
					if (res.last !== want.last) begin
						$error("last: expected %0d, actual %0d", want.last, res.last);
						fail_count++;
					end
					results_checked++;
				end
			end
			if (cfg.valid && cfg.ready) begin
				if (cfg.index == REG_SCHED_MODE)
					mode_now = cfg.data[MODE_W-1:0];
				else if (cfg.index == REG_TRACK_LIMIT)
					limit_now = cfg.data[TRACK_W-1:0];
			end
			if (req.valid && req.ready) begin
				if (req.command == CMD_ADD) begin
					// drop when full, clamp to the limit in force now
					if (queued_count < MAX_REQUESTS) begin
						queued_tracks[queued_count] = (req.track > limit_now) ? limit_now : req.track;
						queued_count++;
					end
				end else begin
					plan_visits(req.track);
					runs_checked++;
				end
			end
		end
		outstanding = expected_visits.size();
	end

endmodule

/* sim/tb.sv */
`timescale 1ns / 1ps
// Top of the disk-arm request scheduler testbench: clock, reset, stimulus and verdict.
// Depends on dars_pkg, the channel interfaces, the scheduler and dars_visit_checker.
module tb;
	import dars_pkg::*;

	localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;   // unused code, behaves as FCFS
	localparam int RANDOM_WORDS = 120;
	localparam int CALM_FROM    = 95;     // no idling on either side past this point
	localparam int LONG_HOLD    = 400;    // receiver hold-off that backs up the block
	localparam int TAIL_CYCLES  = 8;      // covers the add path and output reg
	localparam int RUN_LIMIT_NS = 3_000_000;

	logic clk;
	logic arst_n;

	dars_req_if req ();
	dars_res_if res ();
	dars_cfg_if cfg ();

	int unsigned fail_count;
	int unsigned outstanding;
	int unsigned results_checked;
	int unsigned runs_checked;
	int unsigned words_sent;
	int unsigned reg_writes;
	int unsigned random_words;
	bit          calm;
	bit          long_hold_due;
	bit          holding;

	disk_arm_request_scheduler i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.res    (res),
		.cfg    (cfg)
	);

	dars_visit_checker i_checker (
		.clk             (clk),
		.arst_n          (arst_n),
		.req             (req),
		.res             (res),
		.cfg             (cfg),
		.fail_count      (fail_count),
		.outstanding     (outstanding),
		.results_checked (results_checked),
		.runs_checked    (runs_checked)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Hard stop in case a handshake never completes.
	initial begin
		#(RUN_LIMIT_NS);
		$display("CHECK FAILED");
		$finish;
	end

	// Result receiver: random stall bursts, one long hold-off on
	// request, and a steady ready once the run is in its calm tail.
	initial begin
		int stall_left;
		stall_left = 0;
		holding    = 1'b0;
		res.ready  = 1'b0;
		forever begin
			@(posedge clk);
			if (long_hold_due) begin
				long_hold_due = 1'b0;
				holding       = 1'b1;
				stall_left    = LONG_HOLD;
			end
			if (stall_left > 0) begin
				res.ready <= 1'b0;
				stall_left--;
			end else begin
				holding = 1'b0;
				if (!calm && $urandom_range(0, 5) == 0) begin
					res.ready <= 1'b0;
					stall_left = $urandom_range(0, 3);
				end else begin
					res.ready <= 1'b1;
				end
			end
		end
	end

	// Offer one request word and hold it until the block takes it; now and then
	// valid drops for a gap before the word.
	task automatic send_word(input logic cmd, input logic [TRACK_W-1:0] trk);
		if (!calm && $urandom_range(0, 3) == 0) begin
			req.valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		req.valid   <= 1'b1;
		req.command <= cmd;
		req.track   <= trk;
		@(posedge clk);
		while (!req.ready) @(posedge clk);
		words_sent++;
	endtask

	// Drop valid and wait until every predicted word has come back, then let the
	// block finish any add still in flight.
	task automatic settle();
		req.valid <= 1'b0;
		repeat (2) @(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
	endtask

	// Write both registers back to back; only called while the block is idle.
	task automatic configure(input logic [MODE_W-1:0] mode, input logic [TRACK_W-1:0] limit);
		logic [CFG_DATA_W-1:0] mode_word;
		// upper bits of the mode word are don't-care, so fill them with noise
		mode_word              = CFG_DATA_W'($urandom);
		mode_word[MODE_W-1:0]  = mode;
		cfg.valid <= 1'b1;
		cfg.index <= REG_SCHED_MODE;
		cfg.data  <= mode_word;
		@(posedge clk);
		while (!cfg.ready) @(posedge clk);
		cfg.index <= REG_TRACK_LIMIT;
		cfg.data  <= limit;
		@(posedge clk);
		while (!cfg.ready) @(posedge clk);
		cfg.valid <= 1'b0;
		reg_writes += 2;
	endtask

	initial begin
		int                 n_adds;
		logic [TRACK_W-1:0] lim;
		logic [TRACK_W-1:0] trk;
		logic [TRACK_W-1:0] head;
		logic [TRACK_W-1:0] last_trk;

		arst_n        = 1'b0;
		calm          = 1'b0;
		long_hold_due = 1'b0;
		words_sent    = 0;
		reg_writes    = 0;
		random_words  = 0;
		last_trk      = '0;
		req.valid   <= 1'b0;
		req.command <= CMD_ADD;
		req.track   <= '0;
		cfg.valid   <= 1'b0;
		cfg.index   <= REG_SCHED_MODE;
		cfg.data    <= '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// FCFS at reset settings: empty start gives the head alone, then a run
		// that swings between the track extremes in arrival order.
		send_word(CMD_START, 16'd0);
		send_word(CMD_ADD, 16'hFFFF);
		send_word(CMD_ADD, 16'd0);
		send_word(CMD_ADD, 16'd100);
		send_word(CMD_START, 16'hFFFF);
		settle();

		// SCAN with a low limit: clamp on add, requests on both sides of the head,
		// head above the limit with nothing at or above it, an empty list, and
		// nothing below the head.
		configure(MODE_SCAN, 16'd1000);
		send_word(CMD_ADD, 16'd2000);
		send_word(CMD_ADD, 16'd500);
		send_word(CMD_ADD, 16'd10);
		send_word(CMD_START, 16'd300);
		send_word(CMD_ADD, 16'd50);
		send_word(CMD_START, 16'd60000);
		send_word(CMD_START, 16'd42);
		send_word(CMD_ADD, 16'd700);
		send_word(CMD_START, 16'd0);
		settle();

		// C-SCAN at limit 0: everything clamps to 0, nothing below the head.
		configure(MODE_CSCAN, 16'd0);
		send_word(CMD_ADD, 16'd5);
		send_word(CMD_START, 16'd0);
		settle();

		// C-SCAN with a wrap to track 0, then an empty list.
		configure(MODE_CSCAN, 16'd40000);
		send_word(CMD_ADD, 16'd30000);
		send_word(CMD_ADD, 16'd100);
		send_word(CMD_START, 16'd5000);
		send_word(CMD_START, 16'd39999);
		settle();

		// Spare mode code falls back to FCFS.
		configure(MODE_SPARE, 16'hFFFF);
		send_word(CMD_ADD, 16'd1);
		send_word(CMD_START, 16'd2);
		settle();

		// Fill the list past its depth so the tail adds drop, then hold the
		// receiver off while the run starts and more words are offered behind it.
		configure(MODE_SCAN, 16'd60000);
		for (int i = 0; i < MAX_REQUESTS + 2; i++)
			send_word(CMD_ADD, TRACK_W'($urandom));
		long_hold_due = 1'b1;
		while (!holding) @(posedge clk);
		send_word(CMD_START, 16'd30000);
		for (int i = 0; i < 3; i++)
			send_word(CMD_ADD, TRACK_W'($urandom));
		send_word(CMD_START, TRACK_W'($urandom));
		settle();

		// Random runs: a fresh setting, a handful of adds (now and then enough
		// to overflow), then a start. Tracks lean toward the extremes and the limit.
		while (random_words < RANDOM_WORDS) begin
			calm = (random_words >= CALM_FROM);
			case ($urandom_range(0, 5))
				0:       lim = '0;
				1:       lim = '1;
				2:       lim = TRACK_W'($urandom_range(0, 255));
				default: lim = TRACK_W'($urandom);
			endcase
			configure(MODE_W'($urandom_range(0, 3)), lim);
			n_adds = ($urandom_range(0, 9) == 0) ? $urandom_range(28, 36) : $urandom_range(0, 6);
			for (int i = 0; i < n_adds; i++) begin
				case ($urandom_range(0, 7))
					0:       trk = '0;
					1:       trk = '1;
					2:       trk = lim + TRACK_W'($urandom_range(0, 2)) - 1'b1;
					default: trk = TRACK_W'($urandom);
				endcase
				send_word(CMD_ADD, trk);
				last_trk = trk;
			end
			case ($urandom_range(0, 5))
				0:       head = '0;
				1:       head = '1;
				2:       head = last_trk;
				default: head = TRACK_W'($urandom);
			endcase
			send_word(CMD_START, head);
			random_words += n_adds + 1;
			settle();
		end

		$display("Sent %0d request words over %0d schedule runs with %0d register writes.",
			words_sent, runs_checked, reg_writes);
		$display("Compared %0d result words against the predicted visiting order.",
			results_checked);
		if (fail_count == 0 && outstanding == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule

/* disk_arm_request_scheduler.f */
hw/rtl/dars_pkg.sv
hw/rtl/dars_req_if.sv
hw/rtl/dars_res_if.sv
hw/rtl/dars_cfg_if.sv
hw/rtl/dars_cell.sv
hw/rtl/disk_arm_request_scheduler.sv
sim/dars_visit_checker.sv
sim/tb.sv
